// File: src/bpc_pkg.sv
`timescale 1ns / 1ps

package bpc_pkg;

  // Width of the internal time base; timestamps wrap modulo 2^STAMP_BITS.
  localparam int STAMP_BITS = 32;
  // Width of the saturating tap counter.
  localparam int COUNT_BITS = 4;
  // Fixed widths of the ports.
  localparam int NOW_BITS   = 32;
  localparam int CFG_BITS   = 16;
  localparam int INDEX_BITS = 2;

  typedef logic [STAMP_BITS-1:0] stamp_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [CFG_BITS-1:0]   cfg_word_t;
  typedef logic [INDEX_BITS-1:0] index_t;

  localparam count_t COUNT_ONE = COUNT_BITS'(1);
  localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

  // Register indexes of the configuration port.
  localparam index_t REG_DEBOUNCE   = INDEX_BITS'(0);
  localparam index_t REG_DOUBLE_TAP = INDEX_BITS'(1);
  localparam index_t REG_LONG_PRESS = INDEX_BITS'(2);

  localparam cfg_word_t DEBOUNCE_RESET   = CFG_BITS'(50);
  localparam cfg_word_t DOUBLE_TAP_RESET = CFG_BITS'(300);
  localparam cfg_word_t LONG_PRESS_RESET = CFG_BITS'(1000);

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_NORMAL = 2'd1,
    KIND_DOUBLE = 2'd2,
    KIND_LONG   = 2'd3
  } kind_t;

  typedef struct packed {
    cfg_word_t debounce_ms;
    cfg_word_t double_tap_ms;
    cfg_word_t long_press_ms;
  } cfg_t;

  typedef struct packed {
    logic                button_level;
    logic [NOW_BITS-1:0] now_ms;
    logic                clear_request;
  } item_t;

  typedef struct packed {
    logic  press_latched;
    kind_t press_kind;
    logic  raw_level;
  } result_t;

  // Wrapping difference now - then.
  function automatic stamp_t elapsed(input stamp_t now, input stamp_t then_t);
    elapsed = now - then_t;
  endfunction

  // True when a wrapped interval is strictly longer than a 16-bit limit.
  function automatic logic exceeds(input stamp_t dt, input cfg_word_t limit);
    exceeds = dt > STAMP_BITS'(limit);
  endfunction

endpackage

// File: src/bpc_cfg.sv
`timescale 1ns / 1ps

module bpc_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_enable,
  input  bpc_pkg::index_t    cfg_index,
  input  bpc_pkg::cfg_word_t cfg_data,
  output bpc_pkg::cfg_t      cfg
);
  import bpc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms   <= DEBOUNCE_RESET;
      cfg.double_tap_ms <= DOUBLE_TAP_RESET;
      cfg.long_press_ms <= LONG_PRESS_RESET;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        REG_DEBOUNCE:   cfg.debounce_ms   <= cfg_data;
        REG_DOUBLE_TAP: cfg.double_tap_ms <= cfg_data;
        REG_LONG_PRESS: cfg.long_press_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: src/bpc_core.sv
`timescale 1ns / 1ps

module bpc_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  bpc_pkg::item_t   item,
  input  bpc_pkg::cfg_t    cfg,
  output bpc_pkg::result_t result
);
  import bpc_pkg::*;

  logic   held_down, held_down_next;
  logic   awaiting_window_end, awaiting_window_end_next;
  logic   latched_press, latched_press_next;
  kind_t  latched_kind, latched_kind_next;
  stamp_t last_edge_time, last_edge_time_next;
  stamp_t last_press_time, last_press_time_next;
  stamp_t last_release_time, last_release_time_next;
  count_t tap_count, tap_count_next;

  stamp_t now;
  logic   edge_ok;
  logic   window_over;
  logic   hold_long;

  assign now         = STAMP_BITS'(item.now_ms);
  assign edge_ok     = exceeds(elapsed(now, last_edge_time), cfg.debounce_ms);
  assign window_over = exceeds(elapsed(now, last_release_time), cfg.double_tap_ms);
  assign hold_long   = exceeds(elapsed(last_release_time, last_press_time),
                               cfg.long_press_ms);

  always_comb begin
    held_down_next           = held_down;
    awaiting_window_end_next = awaiting_window_end;
    last_edge_time_next      = last_edge_time;
    last_press_time_next     = last_press_time;
    last_release_time_next   = last_release_time;
    tap_count_next           = tap_count;
    // The clear acts before the sample is used.
    latched_press_next = item.clear_request ? 1'b0 : latched_press;
    latched_kind_next  = item.clear_request ? KIND_NONE : latched_kind;

    if (!item.button_level) begin
      if (!held_down && edge_ok) begin
        if (window_over) begin
          tap_count_next = COUNT_ONE;
        end else if (tap_count != COUNT_MAX) begin
          tap_count_next = tap_count + COUNT_ONE;
        end
        last_press_time_next = now;
        last_edge_time_next  = now;
        held_down_next       = 1'b1;
      end
    end else if (held_down) begin
      if (edge_ok) begin
        last_release_time_next   = now;
        last_edge_time_next      = now;
        held_down_next           = 1'b0;
        awaiting_window_end_next = 1'b1;
      end
    end else if (awaiting_window_end && window_over) begin
      awaiting_window_end_next = 1'b0;
      latched_press_next       = 1'b1;
      if (hold_long) begin
        latched_kind_next = KIND_LONG;
      end else if (tap_count > COUNT_ONE) begin
        latched_kind_next = KIND_DOUBLE;
      end else begin
        latched_kind_next = KIND_NORMAL;
      end
    end

    result.press_latched = latched_press_next;
    result.press_kind    = latched_kind_next;
    result.raw_level     = item.button_level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_down           <= 1'b0;
      awaiting_window_end <= 1'b0;
      latched_press       <= 1'b0;
      latched_kind        <= KIND_NONE;
      last_edge_time      <= '0;
      last_press_time     <= '0;
      last_release_time   <= '0;
      tap_count           <= '0;
    end else if (advance) begin
      held_down           <= held_down_next;
      awaiting_window_end <= awaiting_window_end_next;
      latched_press       <= latched_press_next;
      latched_kind        <= latched_kind_next;
      last_edge_time      <= last_edge_time_next;
      last_press_time     <= last_press_time_next;
      last_release_time   <= last_release_time_next;
      tap_count           <= tap_count_next;
    end
  end

  // The latch flag and the kind are always set and cleared together.
  a_latch_kind: assert property (@(posedge clk) disable iff (rst)
    latched_press == (latched_kind != KIND_NONE))
    else $error("latched flag and press kind disagree");

  // A held button always has at least one counted tap.
  a_held_counted: assert property (@(posedge clk) disable iff (rst)
    held_down |-> (tap_count != '0))
    else $error("button held with zero tap count");

  // Every accepted release opens the repeat window.
  a_release_opens_window: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(held_down)) |-> awaiting_window_end)
    else $error("release did not open the repeat window");

endmodule

// File: src/button_press_classifier_unit.sv
`timescale 1ns / 1ps

// Debounced push-button classifier with long-press and double-press detection.
//
// Input channel (in_valid / in_ready): one sample per transaction carrying the
// active-low button level, a wrapping millisecond timestamp and a clear flag.
// Output channel (out_valid / out_ready): exactly one result transaction per
// input transaction, in order, with the latched flag, press kind and raw level
// as they stand after that sample has been applied.
// Configuration: cfg_write_enable writes cfg_data into the register selected
// by cfg_index (0 debounce, 1 double-tap window, 2 long-press limit) at the
// clock edge; unknown indexes are ignored. Write only while the block is idle.
//
// A sample is first captured in the input register, then the state update and
// classification run in one pass and land in the output register. Throughput
// is one transaction per cycle while the receiver does not stall; the state
// feedback loop through the classifier is not pipelined.
// When the receiver stalls, the pending result holds and the input register can
// still take one more sample; after that in_ready drops until out_ready returns.
// Synchronous reset (rst) empties both registers, clears all press state and
// timestamps to zero and restores the configuration defaults (50, 300, 1000).

module button_press_classifier_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_enable,
  input  bpc_pkg::index_t                  cfg_index,
  input  bpc_pkg::cfg_word_t               cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             button_level,
  input  logic [bpc_pkg::NOW_BITS-1:0]     now_ms,
  input  logic                             clear_request,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             press_latched,
  output logic [1:0]                       press_kind,
  output logic                             raw_level
);
  import bpc_pkg::*;

  cfg_t    cfg;
  item_t   stage_item;
  logic    stage_valid;
  logic    stage_go;
  logic    in_take;
  result_t result;
  result_t out_result;

  // The input register moves forward whenever the output register is empty
  // or is being emptied in the same cycle.
  assign stage_go = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || stage_go;
  assign in_take  = in_valid && in_ready;

  bpc_cfg u_cfg (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cfg              (cfg)
  );

  bpc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (stage_go),
    .item    (stage_item),
    .cfg     (cfg),
    .result  (result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= in_take || (stage_valid && !stage_go);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_item.button_level  <= button_level;
      stage_item.now_ms        <= now_ms;
      stage_item.clear_request <= clear_request;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= stage_go || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go) begin
      out_result <= result;
    end
  end

  assign press_latched = out_result.press_latched;
  assign press_kind    = out_result.press_kind;
  assign raw_level     = out_result.raw_level;

  // A sample that leaves the input register always produces a result next cycle.
  a_go_fills_output: assert property (@(posedge clk) disable iff (rst)
    stage_go |=> out_valid)
    else $error("processed sample did not reach the output register");

endmodule
